### src/u8v_pkg.sv
// Shared types, constants and lookup functions of the UTF-8 stream validator.
package u8v_pkg;

  localparam int NUM_CLASSES = 12;
  localparam int NUM_STATES  = 9;

  localparam logic [3:0] ST_ACCEPT = 4'd0;
  localparam logic [3:0] ST_REJECT = 4'd1;

  localparam logic [1:0] STATUS_VALID     = 2'd0;
  localparam logic [1:0] STATUS_INVALID   = 2'd1;
  localparam logic [1:0] STATUS_TRUNC_BOM = 2'd2;

  localparam logic [1:0] BOM_LEN = 2'd3;

  localparam logic [7:0] BOM_BYTE0 = 8'hEF;
  localparam logic [7:0] BOM_BYTE1 = 8'hBB;
  localparam logic [7:0] BOM_BYTE2 = 8'hBF;

  // Byte class codes.
  localparam logic [3:0] CLS_ASCII   = 4'd0;
  localparam logic [3:0] CLS_CONT_LO = 4'd1;
  localparam logic [3:0] CLS_LEAD2   = 4'd2;
  localparam logic [3:0] CLS_LEAD3   = 4'd3;
  localparam logic [3:0] CLS_ED      = 4'd4;
  localparam logic [3:0] CLS_F4      = 4'd5;
  localparam logic [3:0] CLS_LEAD4   = 4'd6;
  localparam logic [3:0] CLS_CONT_HI = 4'd7;
  localparam logic [3:0] CLS_BAD     = 4'd8;
  localparam logic [3:0] CLS_CONT_MD = 4'd9;
  localparam logic [3:0] CLS_E0      = 4'd10;
  localparam logic [3:0] CLS_F0      = 4'd11;

  localparam logic [3:0] NEXT_TAB [NUM_STATES][NUM_CLASSES] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] cls;
    logic       byte_present;
    logic       last_item;
  } item_t;

  function automatic logic [3:0] classify_byte(input logic [7:0] b);
    logic [3:0] c;
    priority if (b <= 8'h7F) c = CLS_ASCII;
    else if (b <= 8'h8F) c = CLS_CONT_LO;
    else if (b <= 8'h9F) c = CLS_CONT_MD;
    else if (b <= 8'hBF) c = CLS_CONT_HI;
    else if (b <= 8'hC1) c = CLS_BAD;
    else if (b <= 8'hDF) c = CLS_LEAD2;
    else if (b == 8'hE0) c = CLS_E0;
    else if (b == 8'hED) c = CLS_ED;
    else if (b <= 8'hEF) c = CLS_LEAD3;
    else if (b == 8'hF0) c = CLS_F0;
    else if (b <= 8'hF3) c = CLS_LEAD4;
    else if (b == 8'hF4) c = CLS_F4;
    else c = CLS_BAD;
    return c;
  endfunction

  function automatic logic [3:0] dfa_step(input logic [3:0] st, input logic [3:0] cls);
    logic [3:0] n;
    if (st >= 4'(NUM_STATES) || cls >= 4'(NUM_CLASSES)) begin
      n = ST_REJECT;
    end else begin
      n = NEXT_TAB[st][cls];
    end
    return n;
  endfunction

  function automatic logic [7:0] bom_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = BOM_BYTE0;
      2'd1:    b = BOM_BYTE1;
      2'd2:    b = BOM_BYTE2;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### src/u8v_front.sv
// Front stage: accepts input items, classifies the byte and feeds the queue.
module u8v_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [7:0]       data_byte,
  input  logic             byte_present,
  input  logic             last_item,
  output logic             push,
  output u8v_pkg::item_t   push_item,
  input  logic             q_full
);

  logic           stage_valid;
  u8v_pkg::item_t stage_item;
  logic           accept;
  logic           keep;

  assign push       = stage_valid && !q_full;
  assign push_item  = stage_item;
  assign item_stall = stage_valid && q_full;
  assign accept     = item_valid && !item_stall;
  // drop end markers that do not close a string
  assign keep       = byte_present || last_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept && keep) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      stage_item.data_byte    <= data_byte;
      stage_item.cls          <= u8v_pkg::classify_byte(data_byte);
      stage_item.byte_present <= byte_present;
      stage_item.last_item    <= last_item;
    end
  end

endmodule

### src/u8v_queue.sv
// Short FIFO of classified items between the front and back stages.
module u8v_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u8v_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output u8v_pkg::item_t q_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8v_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

### src/u8v_back.sv
// Back stage: runs the UTF-8 automaton and BOM compare, and holds the result.
module u8v_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           bom_check_enable,
  input  logic           q_valid,
  input  u8v_pkg::item_t q_item,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [1:0]     status,
  output logic           bom_found
);

  logic [3:0] dfa_state;
  logic [1:0] bom_matched;
  logic       bom_comparing;
  logic       bom_seen;

  logic [3:0] dfa_state_next;
  logic [1:0] bom_matched_next;
  logic       bom_comparing_next;
  logic       bom_seen_next;
  logic [1:0] status_next;
  logic       out_free;

  assign out_free = !result_valid || !result_stall;
  // a non-final item needs no output slot
  assign pop      = q_valid && (!q_item.last_item || out_free);

  always_comb begin
    dfa_state_next     = dfa_state;
    bom_matched_next   = bom_matched;
    bom_comparing_next = bom_comparing;
    bom_seen_next      = bom_seen;
    if (q_item.byte_present) begin
      dfa_state_next = u8v_pkg::dfa_step(dfa_state, q_item.cls);
      if (bom_comparing) begin
        if (bom_check_enable && bom_matched != u8v_pkg::BOM_LEN &&
            q_item.data_byte == u8v_pkg::bom_byte(bom_matched)) begin
          bom_matched_next = bom_matched + 1'b1;
          if (bom_matched == u8v_pkg::BOM_LEN - 1'b1) begin
            bom_seen_next      = 1'b1;
            bom_comparing_next = 1'b0;
          end
        end else begin
          bom_comparing_next = 1'b0;
        end
      end
    end
    priority if (bom_check_enable && bom_comparing_next && bom_matched_next != 2'd0 &&
                 bom_matched_next != u8v_pkg::BOM_LEN) begin
      status_next = u8v_pkg::STATUS_TRUNC_BOM;
    end else if (dfa_state_next != u8v_pkg::ST_ACCEPT) begin
      status_next = u8v_pkg::STATUS_INVALID;
    end else begin
      status_next = u8v_pkg::STATUS_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state     <= u8v_pkg::ST_ACCEPT;
      bom_matched   <= 2'd0;
      bom_comparing <= 1'b1;
      bom_seen      <= 1'b0;
    end else if (pop) begin
      if (q_item.last_item) begin
        dfa_state     <= u8v_pkg::ST_ACCEPT;
        bom_matched   <= 2'd0;
        bom_comparing <= 1'b1;
        bom_seen      <= 1'b0;
      end else begin
        dfa_state     <= dfa_state_next;
        bom_matched   <= bom_matched_next;
        bom_comparing <= bom_comparing_next;
        bom_seen      <= bom_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && q_item.last_item) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last_item) begin
      status    <= status_next;
      bom_found <= bom_seen_next;
    end
  end

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    dfa_state < 4'(u8v_pkg::NUM_STATES))
    else $error("automaton state out of range");
  a_bom_seen: assert property (@(posedge clk) disable iff (rst)
    bom_seen |-> (bom_matched == u8v_pkg::BOM_LEN && !bom_comparing))
    else $error("BOM flag without full match");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_item.last_item && result_valid && result_stall))
    else $error("result overwritten while stalled");
  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && q_item.last_item) |=> (dfa_state == u8v_pkg::ST_ACCEPT && bom_comparing))
    else $error("string state not cleared after result");

endmodule

### src/utf8_stream_validator.sv
// Top level of the UTF-8 stream validator: front stage, item queue, back stage.
//
// The validator takes one byte item per cycle on the item channel while item_stall is low
// and gives one result on the result channel for each item that has last_item set.
// Sustained rate is one item per clock when nothing stalls: the front stage classifies the
// byte with a chain of range compares while the back stage advances the 9-state
// automaton with one table step per byte, and the queue of QUEUE_DEPTH entries between
// them lets either side stall alone. When nothing stalls, a final item passes the front
// register, the queue and the result register in that order before result_valid rises.
// The result register is refilled in the same cycle it is drained, so back-to-back short
// strings also run at one item per cycle when nothing stalls. bom_check_enable resets
// to 1 and is written through the cfg channel, which is always ready; write it only
// while no string is in flight.
module utf8_stream_validator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // item channel
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       last_item,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] status,
  output logic       bom_found,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic           bom_check_enable;
  logic           push;
  u8v_pkg::item_t push_item;
  logic           q_full;
  logic           pop;
  logic           q_valid;
  u8v_pkg::item_t q_item;

  // Accept a configuration transfer in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bom_check_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      bom_check_enable <= cfg_data;
    end
  end

  // Classify and register each transfer; end markers that close nothing are dropped.
  u8v_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last_item    (last_item),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  // Hold classified items until the back stage takes them.
  u8v_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Advance the automaton and BOM compare; load the result on each final item.
  u8v_back u_back (
    .clk              (clk),
    .rst              (rst),
    .bom_check_enable (bom_check_enable),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .pop              (pop),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .status           (status),
    .bom_found        (bom_found)
  );

endmodule

### dv/tb_utf8_stream_validator.sv
// Self-checking testbench of the UTF-8 stream validator: directed table, then random strings.
module tb_utf8_stream_validator;

  // Hard stop for a hung run; the slowest correct run stays far below this.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 300;
  localparam int HOLD_AT_ITEM = 450;
  localparam int HOLD_CYCLES = 120;
  localparam int CALM_FROM = 750;
  localparam int CALM_TO = 1000;
  localparam int IDLE_PCT = 14;
  localparam int DRAIN_CYCLES = 8;

  // Transition table of the automaton: row is the current state, column the byte class.
  localparam logic [3:0] DFA_NEXT [u8v_pkg::NUM_STATES][u8v_pkg::NUM_CLASSES] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  localparam logic [7:0] BOM_SEQ [3] = '{u8v_pkg::BOM_BYTE0, u8v_pkg::BOM_BYTE1,
                                         u8v_pkg::BOM_BYTE2};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One directed row: an item, or a write of the enable (value in the present column).
  // Where typed is set, the expected verdict is given in the row itself.
  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       typed;
    logic [1:0] status;
    logic       bom;
  } dir_row_t;

  typedef struct packed {
    logic [1:0] status;
    logic       bom;
  } verdict_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } str_item_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty string: end marker alone
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b1, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'h7F, 1'b1, 1'b1, 1'b1, u8v_pkg::STATUS_VALID,     1'b0},
    // full byte order mark
    '{ROW_ITEM, 8'hEF, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hBB, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hBF, 1'b1, 1'b1, 1'b1, u8v_pkg::STATUS_VALID,     1'b1},
    // truncated byte order mark after one and after two bytes
    '{ROW_ITEM, 8'hEF, 1'b1, 1'b1, 1'b1, u8v_pkg::STATUS_TRUNC_BOM, 1'b0},
    '{ROW_ITEM, 8'hEF, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hBB, 1'b1, 1'b1, 1'b1, u8v_pkg::STATUS_TRUNC_BOM, 1'b0},
    // end marker that does not end the string, then the top byte value
    '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, 1'b1, u8v_pkg::STATUS_INVALID,   1'b0},
    '{ROW_ITEM, 8'hC0, 1'b1, 1'b1, 1'b1, u8v_pkg::STATUS_INVALID,   1'b0},
    // lowest three-byte form, surrogate range, highest code point
    '{ROW_ITEM, 8'hE0, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hA0, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'h80, 1'b1, 1'b1, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hED, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hA0, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'h80, 1'b1, 1'b1, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hF4, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'h8F, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hBF, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hBF, 1'b1, 1'b1, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    // checking off: a full mark is not reported, a partial one is just incomplete
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hEF, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hBB, 1'b1, 1'b0, 1'b0, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hBF, 1'b1, 1'b1, 1'b1, u8v_pkg::STATUS_VALID,     1'b0},
    '{ROW_ITEM, 8'hEF, 1'b1, 1'b1, 1'b1, u8v_pkg::STATUS_INVALID,   1'b0}
  };

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_item;
  logic       result_valid;
  logic       result_stall;
  logic [1:0] status;
  logic       bom_found;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  utf8_stream_validator u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last_item    (last_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .bom_found    (bom_found),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Predictor copy of the block state and of the enable register.
  logic [3:0] pv_state;
  logic [1:0] pv_bom_cnt;
  logic       pv_comparing;
  logic       pv_seen;
  logic       pv_bom_en;

  verdict_t   verdict_q [$];
  logic [7:0] bytes_q [$];
  str_item_t  str_q [$];

  int  err_count;
  int  items_accepted;
  int  strings_sent;
  int  results_checked;
  int  settings_written;
  int  status_count [3];
  int  bom_count;
  int  cycle_count;
  bit  calm;
  bit  hold_rx;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Map a byte to its class code.
  function automatic logic [3:0] char_class(input logic [7:0] b);
    logic [3:0] c;
    if (b <= 8'h7F) c = u8v_pkg::CLS_ASCII;
    else if (b <= 8'h8F) c = u8v_pkg::CLS_CONT_LO;
    else if (b <= 8'h9F) c = u8v_pkg::CLS_CONT_MD;
    else if (b <= 8'hBF) c = u8v_pkg::CLS_CONT_HI;
    else if (b <= 8'hC1) c = u8v_pkg::CLS_BAD;
    else if (b <= 8'hDF) c = u8v_pkg::CLS_LEAD2;
    else if (b == 8'hE0) c = u8v_pkg::CLS_E0;
    else if (b == 8'hED) c = u8v_pkg::CLS_ED;
    else if (b <= 8'hEF) c = u8v_pkg::CLS_LEAD3;
    else if (b == 8'hF0) c = u8v_pkg::CLS_F0;
    else if (b <= 8'hF3) c = u8v_pkg::CLS_LEAD4;
    else if (b == 8'hF4) c = u8v_pkg::CLS_F4;
    else c = u8v_pkg::CLS_BAD;
    return c;
  endfunction

  function automatic void clear_string_state();
    pv_state     = u8v_pkg::ST_ACCEPT;
    pv_bom_cnt   = 2'd0;
    pv_comparing = 1'b1;
    pv_seen      = 1'b0;
  endfunction

  // Advance the predictor by one item; return 1 and the verdict when the string ends.
  function automatic bit advance_validator(input logic [7:0] b, input logic present,
                                           input logic last, output verdict_t v);
    logic [3:0] cur;
    v = '0;
    if (present) begin
      cur = (pv_state < u8v_pkg::NUM_STATES) ? pv_state : u8v_pkg::ST_REJECT;
      pv_state = DFA_NEXT[cur][char_class(b)];
      // The leading bytes also run through the mark comparison.
      if (pv_comparing) begin
        if (pv_bom_en && pv_bom_cnt < u8v_pkg::BOM_LEN && b == BOM_SEQ[pv_bom_cnt]) begin
          pv_bom_cnt = pv_bom_cnt + 2'd1;
          if (pv_bom_cnt == u8v_pkg::BOM_LEN) begin
            pv_seen      = 1'b1;
            pv_comparing = 1'b0;
          end
        end else begin
          pv_comparing = 1'b0;
        end
      end
    end
    if (!last) return 1'b0;
    // A partial mark outranks a bad sequence.
    if (pv_bom_en && pv_comparing && pv_bom_cnt != 2'd0 && pv_bom_cnt < u8v_pkg::BOM_LEN)
      v.status = u8v_pkg::STATUS_TRUNC_BOM;
    else if (pv_state != u8v_pkg::ST_ACCEPT)
      v.status = u8v_pkg::STATUS_INVALID;
    else
      v.status = u8v_pkg::STATUS_VALID;
    v.bom = pv_seen;
    clear_string_state();
    return 1'b1;
  endfunction

  // Offer one item with random idle gaps; on transfer, queue its verdict if it ends a string.
  task automatic send_item(input logic [7:0] b, input logic present, input logic last,
                           input logic typed, input verdict_t typed_v);
    verdict_t v;
    calm = (items_accepted >= CALM_FROM && items_accepted < CALM_TO);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid   <= 1'b1;
    data_byte    <= b;
    byte_present <= present;
    last_item    <= last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_accepted++;
    if (advance_validator(b, present, last, v)) begin
      verdict_q.push_back(typed ? typed_v : v);
      strings_sent++;
    end
  endtask

  // Drain every pending verdict, let the pipeline settle, then write the enable.
  task automatic write_enable(input logic value);
    item_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pv_bom_en = value;
    settings_written++;
  endtask

  task automatic push_cont(input int lo, input int hi);
    bytes_q.push_back(8'($urandom_range(hi, lo)));
  endtask

  // Append one well-formed code point of random length.
  task automatic append_code_point();
    int n;
    logic [7:0] lead;
    n = $urandom_range(4, 1);
    case (n)
      1: begin
        bytes_q.push_back(8'($urandom_range(8'h7F, 8'h00)));
      end
      2: begin
        bytes_q.push_back(8'($urandom_range(8'hDF, 8'hC2)));
        push_cont(8'h80, 8'hBF);
      end
      3: begin
        lead = 8'($urandom_range(8'hEF, 8'hE0));
        bytes_q.push_back(lead);
        if (lead == 8'hE0) push_cont(8'hA0, 8'hBF);
        else if (lead == 8'hED) push_cont(8'h80, 8'h9F);
        else push_cont(8'h80, 8'hBF);
        push_cont(8'h80, 8'hBF);
      end
      default: begin
        lead = 8'($urandom_range(8'hF4, 8'hF0));
        bytes_q.push_back(lead);
        if (lead == 8'hF0) push_cont(8'h90, 8'hBF);
        else if (lead == 8'hF4) push_cont(8'h80, 8'h8F);
        else push_cont(8'h80, 8'hBF);
        push_cont(8'h80, 8'hBF);
        push_cont(8'h80, 8'hBF);
      end
    endcase
  endtask

  // Build one random string into str_q: mostly well-formed, some noise, some broken.
  task automatic build_string();
    int mode;
    int nchar;
    int k;
    bytes_q.delete();
    str_q.delete();
    mode = $urandom_range(99);
    // Lead with a full or partial mark in about a third of the strings.
    if ($urandom_range(99) < 35) begin
      k = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 3;
      for (int i = 0; i < k; i++) bytes_q.push_back(BOM_SEQ[i]);
    end
    if (mode < 75) begin
      nchar = $urandom_range(6, 0);
      for (int i = 0; i < nchar; i++) append_code_point();
    end else if (mode < 88) begin
      nchar = $urandom_range(6, 1);
      for (int i = 0; i < nchar; i++) bytes_q.push_back(8'($urandom_range(255)));
    end else begin
      nchar = $urandom_range(4, 1);
      for (int i = 0; i < nchar; i++) append_code_point();
      // Break it: drop the tail byte or overwrite one byte.
      if ($urandom_range(1) == 0) void'(bytes_q.pop_back());
      else bytes_q[$urandom_range(bytes_q.size() - 1)] = 8'($urandom_range(255));
    end
    foreach (bytes_q[i]) begin
      if ($urandom_range(99) < 5)
        str_q.push_back('{8'($urandom_range(255)), 1'b0, 1'b0});
      str_q.push_back('{bytes_q[i], 1'b1, 1'b0});
    end
    // End on the final byte, or on a bare end marker.
    if (str_q.size() == 0 || $urandom_range(4) == 0)
      str_q.push_back('{8'($urandom_range(255)), 1'b0, 1'b1});
    else
      str_q[str_q.size() - 1].last = 1'b1;
  endtask

  // Result side: stall at random, hold off on request, check every transfer in order.
  initial begin
    verdict_t want;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d bom_found %0d",
                   $time, status, bom_found);
          err_count++;
        end else begin
          want = verdict_q.pop_front();
          if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
            err_count++;
          end
          if (bom_found !== want.bom) begin
            $display("%0t: bom_found mismatch, expected %0d, actual %0d",
                     $time, want.bom, bom_found);
            err_count++;
          end
          results_checked++;
          if (want.status <= u8v_pkg::STATUS_TRUNC_BOM) status_count[want.status]++;
          if (want.bom) bom_count++;
        end
      end
      if (hold_rx) result_stall <= 1'b1;
      else if (calm) result_stall <= 1'b0;
      else result_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Long receiver hold-off while the sender keeps offering items; fills the block.
  initial begin
    hold_rx <= 1'b0;
    while (items_accepted < HOLD_AT_ITEM) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Watchdog: end a hung run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout, %0d verdicts still pending", $time, verdict_q.size());
        $display("tb_utf8_stream_validator failed");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed table, then random phases over alternating enable values.
  initial begin
    verdict_t tv;
    int phase_items;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    data_byte    <= 8'h00;
    byte_present <= 1'b0;
    last_item    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_data     <= 1'b0;
    err_count        = 0;
    items_accepted   = 0;
    strings_sent     = 0;
    results_checked  = 0;
    settings_written = 0;
    bom_count        = 0;
    status_count     = '{0, 0, 0};
    calm             = 1'b0;
    pv_bom_en        = 1'b1;
    clear_string_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table.
    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        write_enable(DIR_TABLE[i].present);
      end else begin
        tv.status = DIR_TABLE[i].status;
        tv.bom    = DIR_TABLE[i].bom;
        send_item(DIR_TABLE[i].data, DIR_TABLE[i].present, DIR_TABLE[i].last,
                  DIR_TABLE[i].typed, tv);
      end
    end

    // Random phases; each ends on a finished string so the enable write sees an idle block.
    for (int ph = 0; ph < 4; ph++) begin
      write_enable(ph[0]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_string();
        foreach (str_q[j]) begin
          send_item(str_q[j].data, str_q[j].present, str_q[j].last, 1'b0, '0);
          if (str_q[j].present || str_q[j].last) phase_items++;
        end
      end
    end

    // Drop valid, wait out every pending verdict, then watch for stray results.
    item_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items in %0d strings over %0d enable writes, %0d results checked",
             items_accepted, strings_sent, settings_written, results_checked);
    $display("verdicts: %0d valid, %0d invalid, %0d truncated mark, %0d with mark found",
             status_count[0], status_count[1], status_count[2], bom_count);
    if (err_count == 0) begin
      $display("tb_utf8_stream_validator passed");
    end else begin
      $display("tb_utf8_stream_validator failed");
    end
    $finish;
  end

endmodule
